### hw/rtl/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

    localparam int DATA_W   = 64;
    localparam int CHECK_W  = 8;
    localparam int SYN_W    = 7;
    localparam int STATUS_W = 2;

    localparam int DEF_DATA_LEN   = 64;
    localparam int DEF_CHECK_BITS = 7;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 2'd0,
        ST_DOUBLE  = 2'd1,
        ST_OVERALL = 2'd2,
        ST_SINGLE  = 2'd3
    } t_status;

    function automatic bit is_chk_pos(int p, int cb);
        return ((p & (p - 1)) == 0) && (p < (1 << cb));
    endfunction

    // one-based codeword position of data bit n
    function automatic int data_pos(int n, int cb);
        int p;
        int cnt;
        int res;
        cnt = 0;
        res = 0;
        for (p = 1; p < 256; p++) begin
            if (!is_chk_pos(p, cb)) begin
                if (cnt == n && res == 0) begin
                    res = p;
                end
                cnt++;
            end
        end
        return res;
    endfunction

    // data_word bits covered by check bit i
    function automatic logic [DATA_W-1:0] check_mask(int i, int db, int cb);
        logic [DATA_W-1:0] m;
        int n;
        int p;
        m = '0;
        for (n = 0; n < db; n++) begin
            p = data_pos(n, cb);
            if (((p >> i) & 1) != 0) begin
                m[db-1-n] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hsc_datapath.sv
`default_nettype none

module hsc_datapath #(
    parameter int DATA_LEN   = hsc_pkg::DEF_DATA_LEN,
    parameter int CHECK_BITS = hsc_pkg::DEF_CHECK_BITS
) (
    input  wire logic                         i_op,
    input  wire logic [hsc_pkg::DATA_W-1:0]   i_data_word,
    input  wire logic [hsc_pkg::CHECK_W-1:0]  i_check_in,
    output logic      [hsc_pkg::DATA_W-1:0]   o_data_out,
    output logic      [hsc_pkg::CHECK_W-1:0]  o_check_out,
    output hsc_pkg::t_status                  o_status,
    output logic      [hsc_pkg::SYN_W-1:0]    o_error_position
);
    import hsc_pkg::*;

    localparam int NPOS = DATA_LEN + CHECK_BITS;
    localparam logic [DATA_W-1:0] DMASK = DATA_W'(~64'd0 >> (DATA_W - DATA_LEN));

    logic [SYN_W-1:0]   chk;
    logic [SYN_W-1:0]   rc;
    logic [SYN_W-1:0]   syn;
    logic [DATA_W-1:0]  flip;
    logic [SYN_W-1:0]   cflip;
    logic               dpar;
    logic               ov_enc;
    logic               ov_dec;
    logic               single_err;
    t_status            dec_status;

    genvar gi;
    generate
        for (gi = 0; gi < SYN_W; gi++) begin : g_chk
            if (gi < CHECK_BITS) begin : g_used
                localparam logic [DATA_W-1:0] MASK = check_mask(gi, DATA_LEN, CHECK_BITS);
                assign chk[gi] = ^(i_data_word & MASK);
                assign rc[gi]  = i_check_in[gi];
                if ((1 << gi) <= NPOS) begin : g_fix
                    assign cflip[gi] = single_err && (syn == SYN_W'(1 << gi));
                end else begin : g_nofix
                    assign cflip[gi] = 1'b0;
                end
            end else begin : g_unused
                assign chk[gi]   = 1'b0;
                assign rc[gi]    = 1'b0;
                assign cflip[gi] = 1'b0;
            end
        end

        for (gi = 0; gi < DATA_W; gi++) begin : g_flip
            if (gi < DATA_LEN) begin : g_used
                localparam int POS = data_pos(DATA_LEN - 1 - gi, CHECK_BITS);
                assign flip[gi] = single_err && (syn == SYN_W'(POS));
            end else begin : g_unused
                assign flip[gi] = 1'b0;
            end
        end
    endgenerate

    assign dpar       = ^(i_data_word & DMASK);
    assign ov_enc     = dpar ^ (^chk);
    assign ov_dec     = dpar ^ (^rc) ^ i_check_in[CHECK_BITS];
    assign syn        = chk ^ rc;
    assign single_err = (syn != '0) && ov_dec;

    always_comb begin
        if (syn != '0 && !ov_dec) begin
            dec_status = ST_DOUBLE;
        end else if (syn == '0 && ov_dec) begin
            dec_status = ST_OVERALL;
        end else if (syn != '0 && ov_dec) begin
            dec_status = ST_SINGLE;
        end else begin
            dec_status = ST_NONE;
        end
    end

    always_comb begin
        o_check_out = '0;
        if (i_op == OP_ENCODE) begin
            o_data_out               = i_data_word;
            o_check_out[SYN_W-1:0]   = chk;
            o_check_out[CHECK_BITS]  = ov_enc;
            o_status                 = ST_NONE;
            o_error_position         = '0;
        end else begin
            o_data_out               = i_data_word ^ flip;
            o_check_out[SYN_W-1:0]   = rc ^ cflip;
            o_check_out[CHECK_BITS]  = i_check_in[CHECK_BITS] ^ (dec_status == ST_OVERALL);
            o_status                 = dec_status;
            o_error_position         = syn;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hamming_secded_codec_core.sv
`default_nettype none

// Pipeline: input register, then result register, between input transaction and result.
// Throughput: one transaction per cycle unless i_stall holds the output; the parity
//   trees and the correction decode sit in one pass between the two registers.
// Reset: synchronous, active low; clears both valid flags, payload registers
//   are not reset.
module hamming_secded_codec_core #(
    parameter int DATA_LEN   = hsc_pkg::DEF_DATA_LEN,
    parameter int CHECK_BITS = hsc_pkg::DEF_CHECK_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_op,
    input  wire logic [hsc_pkg::DATA_W-1:0]    i_data_word,
    input  wire logic [hsc_pkg::CHECK_W-1:0]   i_check_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [hsc_pkg::DATA_W-1:0]    o_data_out,
    output logic      [hsc_pkg::CHECK_W-1:0]   o_check_out,
    output logic      [hsc_pkg::STATUS_W-1:0]  o_status,
    output logic      [hsc_pkg::SYN_W-1:0]     o_error_position
);
    import hsc_pkg::*;

    logic                r_in_valid;
    logic                r_op;
    logic [DATA_W-1:0]   r_data;
    logic [CHECK_W-1:0]  r_check;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_data_out;
    logic [CHECK_W-1:0]  r_check_out;
    t_status             r_status;
    logic [SYN_W-1:0]    r_err_pos;

    logic [DATA_W-1:0]   n_data_out;
    logic [CHECK_W-1:0]  n_check_out;
    t_status             n_status;
    logic [SYN_W-1:0]    n_err_pos;

    logic                out_en;
    logic                in_en;

    assign out_en  = !r_out_valid || !i_stall;
    assign in_en   = !r_in_valid || out_en;
    assign o_stall = !in_en;

    hsc_datapath #(
        .DATA_LEN   (DATA_LEN),
        .CHECK_BITS (CHECK_BITS)
    ) u_datapath (
        .i_op             (r_op),
        .i_data_word      (r_data),
        .i_check_in       (r_check),
        .o_data_out       (n_data_out),
        .o_check_out      (n_check_out),
        .o_status         (n_status),
        .o_error_position (n_err_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_en) begin
                r_in_valid <= i_valid;
            end
            if (out_en) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && i_valid) begin
            r_op    <= i_op;
            r_data  <= i_data_word;
            r_check <= i_check_in;
        end
        if (out_en && r_in_valid) begin
            r_data_out  <= n_data_out;
            r_check_out <= n_check_out;
            r_status    <= n_status;
            r_err_pos   <= n_err_pos;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_data_out       = r_data_out;
    assign o_check_out      = r_check_out;
    assign o_status         = r_status;
    assign o_error_position = r_err_pos;

endmodule

`default_nettype wire
